### src/nsrs_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Newton square root solver package
// Word formats, register map, outcome codes and the controller/datapath
// command and status bundles.
// -----------------------------------------------------------------------------
package nsrs_pkg;

	// Signed fixed-point word, Q8.24.
	localparam int WORD_W    = 32;
	localparam int FRAC_BITS = 24;

	// Register and result field widths.
	localparam int TGT_W     = 31;
	localparam int TOL_W     = 31;
	localparam int LIMIT_W   = 8;
	localparam int STEP_W    = 8;
	localparam int OUTCOME_W = 2;

	// Exact square of the iterate magnitude and the signed residual.
	localparam int PROD_W = 2 * WORD_W;
	// One quotient bit per division step over the whole residual.
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	// Exact x - quotient before saturation.
	localparam int R_W = PROD_W + 1;

	localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// Stream widths.
	localparam int IN_TDATA_W  = WORD_W;
	localparam int OUT_FIELD_W = WORD_W + STEP_W + OUTCOME_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// Register port.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_TARGET = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_TOL    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_LIMIT  = REG_IDX_W'(2);

	localparam logic [TGT_W-1:0]   TARGET_RST = TGT_W'(33554432);
	localparam logic [TOL_W-1:0]   TOL_RST    = TOL_W'(17);
	localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(20);

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_CONVERGED  = 2'd0,
		OUT_DERIV_ZERO = 2'd1,
		OUT_LIMIT      = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [TGT_W-1:0]   target;
		logic [TOL_W-1:0]   tol;
		logic [LIMIT_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic     load;
		logic     capture_mag;
		logic     square;
		logic     prep;
		logic     div_step;
		logic     update;
		logic     apply;
		logic     emit;
		outcome_t outcome;
	} dp_cmd_t;

	typedef struct packed {
		logic limit_hit;
		logic x_zero;
		logic div_done;
		logic converged;
		logic out_free;
	} dp_status_t;

endpackage

### src/nsrs_regs.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Newton square root solver registers
// APB register file holding target square, tolerance and iteration limit.
// -----------------------------------------------------------------------------
module nsrs_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [nsrs_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [nsrs_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [nsrs_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output nsrs_pkg::cfg_t                   cfg
);
	import nsrs_pkg::*;

	logic [TGT_W-1:0]     target_q;
	logic [TOL_W-1:0]     tol_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			tol_q    <= TOL_RST;
			limit_q  <= LIMIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TARGET: begin
					target_q <= pwdata[TGT_W-1:0];
				end
				REG_TOL: begin
					tol_q <= pwdata[TOL_W-1:0];
				end
				REG_LIMIT: begin
					limit_q <= pwdata[LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TARGET: prdata = APB_DATA_W'(target_q);
			REG_TOL:    prdata = APB_DATA_W'(tol_q);
			REG_LIMIT:  prdata = APB_DATA_W'(limit_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.target = target_q;
	assign cfg.tol    = tol_q;
	assign cfg.limit  = limit_q;

endmodule

### src/nsrs_dp.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Newton square root solver datapath
// Iterate registers, squarer, bit-serial divider, update and output register.
// -----------------------------------------------------------------------------
module nsrs_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  nsrs_pkg::cfg_t                     cfg,
	input  nsrs_pkg::dp_cmd_t                  cmd,
	output nsrs_pkg::dp_status_t               status,
	input  logic [nsrs_pkg::WORD_W-1:0]        guess,
	output logic [nsrs_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready
);
	import nsrs_pkg::*;

	logic [WORD_W-1:0]    x_q;
	logic [STEP_W-1:0]    n_q;
	logic [WORD_W-1:0]    xmag_q;
	logic                 xneg_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 fneg_q;
	logic [PROD_W-1:0]    dq_q;
	logic [WORD_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [WORD_W-1:0]    xn_q;
	logic [WORD_W-1:0]    root_q;
	logic [STEP_W-1:0]    steps_q;
	outcome_t             outcome_q;
	logic                 out_valid_q;

	logic [WORD_W-1:0]    x_mag;
	logic [PROD_W:0]      f_full;
	logic [PROD_W:0]      f_neg;
	logic [PROD_W-1:0]    f_abs;
	logic [WORD_W:0]      rem_sh;
	logic [WORD_W:0]      rem_sub;
	logic                 fits;
	logic [WORD_W-1:0]    rem_next;
	logic [PROD_W-2:0]    q_mag;
	logic [R_W-1:0]       x_ext;
	logic [R_W-1:0]       q_ext;
	logic [R_W-1:0]       r_full;
	logic [R_W-WORD_W:0]  r_top;
	logic                 r_in_range;
	logic [WORD_W-1:0]    xn_d;
	logic [WORD_W:0]      diff;
	logic [WORD_W:0]      diff_neg;
	logic [WORD_W:0]      diff_abs;

	assign x_mag = x_q[WORD_W-1] ? (~x_q + WORD_W'(1)) : x_q;

	// Residual x*x - target at 2*FRAC_BITS fraction bits.
	assign f_full = {1'b0, prod_q} - (PROD_W+1)'({cfg.target, {FRAC_BITS{1'b0}}});
	assign f_neg  = ~f_full + (PROD_W+1)'(1);
	assign f_abs  = f_full[PROD_W] ? f_neg[PROD_W-1:0] : f_full[PROD_W-1:0];

	// Restoring division step: the remainder always stays below the divisor.
	assign rem_sh   = {rem_q, dq_q[PROD_W-1]};
	assign rem_sub  = rem_sh - {1'b0, xmag_q};
	assign fits     = rem_sh >= {1'b0, xmag_q};
	assign rem_next = fits ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];

	// Halving the quotient divides by 2x; the sign decides add or subtract.
	assign q_mag  = dq_q[PROD_W-1:1];
	assign x_ext  = {{(R_W-WORD_W){x_q[WORD_W-1]}}, x_q};
	assign q_ext  = R_W'(q_mag);
	assign r_full = (fneg_q ^ xneg_q) ? (x_ext + q_ext) : (x_ext - q_ext);
	assign r_top  = r_full[R_W-1:WORD_W-1];
	assign r_in_range = (&r_top) || !(|r_top);
	assign xn_d = r_in_range ? r_full[WORD_W-1:0] :
	              (r_full[R_W-1] ? WORD_MIN : WORD_MAX);

	// Step size between the saturated new iterate and the current one.
	assign diff     = {xn_q[WORD_W-1], xn_q} - {x_q[WORD_W-1], x_q};
	assign diff_neg = ~diff + (WORD_W+1)'(1);
	assign diff_abs = diff[WORD_W] ? diff_neg : diff;

	assign status.limit_hit = n_q >= cfg.limit;
	assign status.x_zero    = x_q == '0;
	assign status.div_done  = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
	assign status.converged = diff_abs < (WORD_W+1)'(cfg.tol);
	assign status.out_free  = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.prep) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= guess;
			n_q <= '0;
		end else if (cmd.apply) begin
			x_q <= xn_q;
			n_q <= n_q + STEP_W'(1);
		end
		if (cmd.capture_mag) begin
			xmag_q <= x_mag;
			xneg_q <= x_q[WORD_W-1];
		end
		if (cmd.square) begin
			prod_q <= xmag_q * xmag_q;
		end
		if (cmd.prep) begin
			fneg_q <= f_full[PROD_W];
			dq_q   <= f_abs;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[PROD_W-2:0], fits};
			rem_q <= rem_next;
		end
		if (cmd.update) begin
			xn_q <= xn_d;
		end
		if (cmd.emit) begin
			root_q    <= x_q;
			steps_q   <= n_q;
			outcome_q <= cmd.outcome;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({outcome_q, steps_q, root_q});

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < xmag_q)
		else $error("division remainder not below divisor");

	a_update_nonzero_x: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> x_q != '0)
		else $error("Newton update on a zero iterate");

	a_emit_into_free_reg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || m_tready))
		else $error("result overwrites an item not yet taken");

endmodule

### src/nsrs_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Newton square root solver controller
// Sequences check, square, divide and update for each Newton step.
// -----------------------------------------------------------------------------
module nsrs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  nsrs_pkg::dp_status_t   status,
	output nsrs_pkg::dp_cmd_t      cmd
);
	import nsrs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SQUARE,
		ST_PREP,
		ST_DIV,
		ST_UPDATE,
		ST_APPLY,
		ST_FINISH
	} state_t;

	state_t   state_q;
	outcome_t outcome_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			outcome_q <= OUT_LIMIT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (status.limit_hit) begin
						outcome_q <= OUT_LIMIT;
						state_q   <= ST_FINISH;
					end else if (status.x_zero) begin
						outcome_q <= OUT_DERIV_ZERO;
						state_q   <= ST_FINISH;
					end else begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (status.div_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (status.converged) begin
						outcome_q <= OUT_CONVERGED;
						state_q   <= ST_FINISH;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		cmd.load        = (state_q == ST_IDLE) && s_tvalid;
		cmd.capture_mag = state_q == ST_CHECK;
		cmd.square      = state_q == ST_SQUARE;
		cmd.prep        = state_q == ST_PREP;
		cmd.div_step    = state_q == ST_DIV;
		cmd.update      = state_q == ST_UPDATE;
		cmd.apply       = state_q == ST_APPLY;
		cmd.emit        = (state_q == ST_FINISH) && status.out_free;
		cmd.outcome     = outcome_q;
	end

	a_one_item_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while one is being solved");

endmodule

### src/newton_square_root_solver_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Newton square root solver
// Runs Newton-Raphson steps towards the square root of a target, Q8.24.
// -----------------------------------------------------------------------------
//
// Channel   Dir   Handshake                Payload
// s_*       in    s_tvalid / s_tready      s_tdata[31:0]  seed
// m_*       out   m_tvalid / m_tready      m_tdata[47:0]  root_estimate,
//                                          steps_taken, outcome
// APB       in    psel, penable, pwrite    0x0 target_square, 0x4 tolerance,
//                                          0x8 iteration_limit
//
// One item is solved at a time. Each Newton step runs through check, square,
// residual, the one-bit-per-cycle restoring divider, update and step-size
// test. The default iteration limit is twenty steps. Reset clears the
// controller and the output valid and loads the register reset values. A
// result waits in the output register while m_tready is low; the next item
// is taken once the result register is free to receive it.
//
// Each step computes x - (x*x - target) / (2x) exactly, truncating the quotient
// toward zero and saturating the new iterate to the signed word range. The run
// ends on a step smaller than the tolerance, on a zero iterate or at the limit.
// -----------------------------------------------------------------------------
module newton_square_root_solver_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nsrs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [nsrs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [nsrs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	// Input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [nsrs_pkg::IN_TDATA_W-1:0]   s_tdata,   // [31:0] seed
	// Result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [nsrs_pkg::OUT_TDATA_W-1:0]  m_tdata    // [31:0] root_estimate,
	                                                     // [39:32] steps_taken,
	                                                     // [41:40] outcome
);
	import nsrs_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// Configuration registers; the user must write them only between items, the block does not enforce it.
	nsrs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Step sequencer: decides when to stop and which outcome to report.
	nsrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and the output register.
	nsrs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.status   (status),
		.guess    (s_tdata[WORD_W-1:0]),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

endmodule

### sim/newton_square_root_solver_top_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Newton square root solver testbench
// Sends starting guesses to the solver under a range of register settings.
// A predictor in the bench repeats the exact fixed-point Newton iteration for
// each accepted item. The result stream is then checked field by field against
// the oldest prediction still waiting. Both stream sides idle at random, and
// the result side is held off for a long stretch once to fill the block.
// -----------------------------------------------------------------------------
module newton_square_root_solver_top_tb;
	import nsrs_pkg::*;

	// Exact iteration runs in a signed word wide enough for x*x, the scaled
	// target and the difference of the two without any loss.
	localparam int CALC_W = 96;
	localparam logic signed [CALC_W-1:0] WIDE_MAX = 96'sd2147483647;
	localparam logic signed [CALC_W-1:0] WIDE_MIN = -96'sd2147483648;
	localparam real ONE_Q = 16777216.0;

	typedef struct {
		logic [WORD_W-1:0] root;
		logic [STEP_W-1:0] steps;
		outcome_t          outcome;
	} solution_t;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;    // [31:0] seed
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;    // [31:0] root_estimate, [39:32] steps_taken,
	                                    // [41:40] outcome

	// Bench copy of the register file, updated on each register write.
	logic [TGT_W-1:0]   target_q;
	logic [TOL_W-1:0]   tol_q;
	logic [LIMIT_W-1:0] limit_q;

	solution_t pending_solutions[$];
	int        fault_count;
	int        hold_cycles;
	logic      no_idle;

	newton_square_root_solver_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: far beyond the slowest correct run of this stimulus.
	initial begin
		#80_000_000;
		$display("newton_square_root_solver_top_tb failed");
		$finish;
	end

	// Newton iteration on a starting guess under the current registers.
	function automatic solution_t solve_root(input logic [WORD_W-1:0] guess);
		logic signed [CALC_W-1:0] x, xm, f, fa, q, r, d, tgt, tol;
		int        n;
		int        lim;
		logic      done;
		solution_t s;
		x = {{(CALC_W-WORD_W){guess[WORD_W-1]}}, guess};
		tgt = {{(CALC_W-TGT_W){1'b0}}, target_q};
		tgt = tgt <<< FRAC_BITS;
		tol = {{(CALC_W-TOL_W){1'b0}}, tol_q};
		lim = limit_q;
		n = 0;
		done = 1'b0;
		s.outcome = OUT_LIMIT;
		while (!done && n < lim) begin
			if (x == 0) begin
				s.outcome = OUT_DERIV_ZERO;
				done = 1'b1;
			end else begin
				xm = (x < 0) ? -x : x;
				f = xm * xm - tgt;
				fa = (f < 0) ? -f : f;
				// Quotient truncated toward zero, sign taken from f and x.
				q = (fa / xm) >>> 1;
				if ((f < 0) != (x < 0))
					q = -q;
				r = x - q;
				if (r > WIDE_MAX)
					r = WIDE_MAX;
				else if (r < WIDE_MIN)
					r = WIDE_MIN;
				d = r - x;
				if (d < 0)
					d = -d;
				x = r;
				n++;
				if (d < tol) begin
					s.outcome = OUT_CONVERGED;
					done = 1'b1;
				end
			end
		end
		s.root = x[WORD_W-1:0];
		s.steps = n[STEP_W-1:0];
		return s;
	endfunction

	// Mostly guesses within a few times of the true root, plus raw words and
	// tiny values that drive the iterate into saturation.
	function automatic logic [WORD_W-1:0] pick_guess();
		real  v;
		real  rt;
		int   sel;
		logic [WORD_W-1:0] g;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			return $urandom();
		if (sel < 42) begin
			g = $urandom_range(0, 255);
			return $urandom_range(0, 1) ? -g : g;
		end
		v = target_q;
		rt = $sqrt(v / ONE_Q);
		v = rt * ONE_Q * (0.25 + $urandom_range(0, 3000) / 1000.0);
		if (v < 1.0)
			v = $urandom_range(1, 1 << FRAC_BITS);
		if (v > 2147483647.0)
			v = 2147483647.0;
		g = $rtoi(v);
		return ($urandom_range(0, 3) == 0) ? -g : g;
	endfunction

	// One register write: setup cycle, then access cycle until pready.
	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
	                              input logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_TARGET: target_q = value[TGT_W-1:0];
			REG_TOL:    tol_q = value[TOL_W-1:0];
			REG_LIMIT:  limit_q = value[LIMIT_W-1:0];
			default:    ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_registers(input logic [APB_DATA_W-1:0] target,
	                             input logic [APB_DATA_W-1:0] tol,
	                             input logic [APB_DATA_W-1:0] limit);
		write_register(REG_TARGET, target);
		write_register(REG_TOL, tol);
		write_register(REG_LIMIT, limit);
	endtask

	// Offers one guess and records its predicted result once accepted.
	task automatic send_guess(input logic [WORD_W-1:0] guess);
		@(negedge clk);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 25) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= guess;
		do @(posedge clk); while (!s_tready);
		pending_solutions.push_back(solve_root(guess));
	endtask

	// Stops offering and waits until every predicted result has arrived.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_solutions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_guess(32'h0000_0000);
		send_guess(32'h0000_0001);
		send_guess(32'hFFFF_FFFF);
		send_guess(32'h7FFF_FFFF);
		send_guess(32'h8000_0000);
		send_guess(32'h0100_0000);
		send_guess(32'hFF00_0000);
		send_guess(32'h0180_0000);
		send_guess(32'hFE80_0000);
		send_guess(32'h016A_09E6);
		send_guess(32'h0000_0002);
		send_guess(32'h4000_0000);
		wait_idle();
	endtask

	// Largest target with the longest limit; the tiny guesses make the first
	// quotient huge, so the iterate saturates to either end of the word.
	task automatic test_saturation();
		set_registers(32'h7FFF_FFFF, 32'd17, 32'd255);
		send_guess(32'h0000_0001);
		send_guess(32'hFFFF_FFFF);
		send_guess(32'h7FFF_FFFF);
		wait_idle();
	endtask

	// Target of zero and a tolerance written as all ones, which the register
	// masks to its width: nearly every first step counts as converged.
	task automatic test_wide_tolerance();
		set_registers(32'h0000_0000, 32'hFFFF_FFFF, 32'd1);
		send_guess(32'h1234_5678);
		send_guess(32'hFFFF_FFFB);
		send_guess(32'h8000_0000);
		send_guess(32'h0000_0000);
		wait_idle();
	endtask

	// No step at all: the guess comes back unchanged.
	task automatic test_zero_limit();
		set_registers(32'h0200_0000, 32'd17, 32'd0);
		send_guess(32'h0000_0000);
		send_guess(32'h8000_0000);
		send_guess(32'h7FFF_FFFF);
		wait_idle();
	endtask

	// Zero tolerance never reports convergence, so the limit always ends it.
	task automatic test_no_tolerance();
		set_registers(32'h0200_0000, 32'd0, 32'd7);
		send_guess(32'hFD00_0000);
		wait_idle();
		write_register(REG_LIMIT, 32'd255);
		send_guess(32'h0100_0000);
		wait_idle();
	endtask

	task automatic test_random_settings();
		logic [APB_DATA_W-1:0] target;
		logic [APB_DATA_W-1:0] tol;
		for (int phase = 0; phase < 10; phase++) begin
			target = $urandom_range(0, 1) ? $urandom_range(0, 32'h7FFF_FFFF)
			                              : $urandom_range(0, 1 << 28);
			tol = $urandom_range(0, 2) ? $urandom_range(1, 64)
			                           : $urandom_range(64, 1 << 16);
			set_registers(target, tol, $urandom_range(8, 30));
			// One phase runs with neither side idling.
			no_idle = (phase == 4);
			for (int i = 0; i < 58; i++)
				send_guess(pick_guess());
			wait_idle();
			no_idle = 1'b0;
		end
	endtask

	// The result side holds off while guesses keep coming, so one finished
	// result sits in the output register and the input stalls behind it.
	task automatic test_output_backpressure();
		set_registers(32'h0300_0000, 32'd17, 32'd20);
		no_idle = 1'b1;
		hold_cycles = 6000;
		for (int i = 0; i < 40; i++)
			send_guess(pick_guess());
		wait_idle();
		no_idle = 1'b0;
	endtask

	// Result side: random stalls, a stretch of none, and a long hold-off.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (no_idle) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// Every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin : check_results
		solution_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_solutions.size() == 0) begin
				$error("result item with no prediction waiting: %h", m_tdata);
				fault_count++;
			end else begin
				want = pending_solutions.pop_front();
				if (m_tdata[WORD_W-1:0] !== want.root) begin
					$error("root_estimate: expected %h, got %h",
					       want.root, m_tdata[WORD_W-1:0]);
					fault_count++;
				end
				if (m_tdata[WORD_W +: STEP_W] !== want.steps) begin
					$error("steps_taken: expected %0d, got %0d",
					       want.steps, m_tdata[WORD_W +: STEP_W]);
					fault_count++;
				end
				if (m_tdata[WORD_W+STEP_W +: OUTCOME_W] !== want.outcome) begin
					$error("outcome: expected %0d, got %0d",
					       want.outcome, m_tdata[WORD_W+STEP_W +: OUTCOME_W]);
					fault_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		fault_count = 0;
		hold_cycles = 0;
		no_idle = 1'b0;
		target_q = TARGET_RST;
		tol_q = TOL_RST;
		limit_q = LIMIT_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_saturation();
		test_wide_tolerance();
		test_zero_limit();
		test_no_tolerance();
		test_random_settings();
		test_output_backpressure();

		// Room for a stray result to show up after the last expected one.
		repeat (1500) @(posedge clk);
		if (fault_count == 0 && pending_solutions.size() == 0)
			$display("newton_square_root_solver_top_tb passed");
		else
			$display("newton_square_root_solver_top_tb failed");
		$finish;
	end

endmodule
